// File: hdl/quaternion_arithmetic_unit_defines.svh
// assertion macros for the quaternion arithmetic unit
// used by the top level; expects clk_i and rst_ni in scope
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define QAU_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");

// next-cycle implication
`define QAU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");

`endif

// File: hdl/qau_pkg.sv
// shared constants, op and status codes, tag type and saturation helper
// for the quaternion arithmetic unit; no dependencies
package qau_pkg;

  localparam int FracBits = 16;
  localparam int DW       = 32;
  localparam int PW       = 2 * DW;
  localparam int WW       = PW + 2;
  localparam int SumW     = PW + 1;
  localparam int SqW      = SumW + (SumW % 2);
  localparam int SqSteps  = SqW / 2;
  localparam int RootW    = SqSteps;
  localparam int RemW     = RootW + 3;
  localparam int LenW     = RootW;
  localparam int QW       = FracBits + 1;
  localparam int NumW     = DW + FracBits + 1;

  // op codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SCALE = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_CONJ  = 3'd3;
  localparam logic [2:0] OP_MAG   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // per-word side data carried through the sqrt and divide pipes
  typedef struct packed {
    logic                vld;
    logic [2:0]          op;
    logic [3:0][DW-1:0]  res;
    logic                sat;
    logic [3:0][DW-1:0]  a;
  } tag_t;

  // clamp to the signed 32-bit range, flag in the top bit
  function automatic logic [DW:0] sat32(input logic signed [WW-1:0] v);
    logic [DW:0] r;
    if (v > $signed({{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if (v < $signed({{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

// File: hdl/qau_mul.sv
// product bank and combine stage: 16 multipliers, rounding, saturation
// and sum of squares; depends on qau_pkg
module qau_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [2:0]                       op_i,
  input  logic [3:0][qau_pkg::DW-1:0]      a_i,
  input  logic [3:0][qau_pkg::DW-1:0]      b_i,
  input  logic [qau_pkg::DW-1:0]           s_i,
  output logic [qau_pkg::SumW-1:0]         sum_o,
  output qau_pkg::tag_t                    tag_o
);
  import qau_pkg::*;

  logic signed [PW-1:0] prod_d [4][4];
  logic signed [PW-1:0] prod_q [4][4];
  logic                 vld_q;
  logic [2:0]           op_q;
  logic [3:0][DW-1:0]   a_q, b_q;

  // operand select and products
  always_comb begin
    logic [DW-1:0] y;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (op_i == OP_SCALE) begin
          y = s_i;
        end else if (op_i == OP_MAG || op_i == OP_NORM) begin
          y = a_i[j];
        end else begin
          y = b_i[j];
        end
        prod_d[i][j] = $signed({{DW{a_i[i][DW-1]}}, a_i[i]}) * $signed({{DW{y[DW-1]}}, y});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      op_q   <= op_i;
      a_q    <= a_i;
      b_q    <= b_i;
    end
  end

  // combine products into per-part results
  logic signed [WW-1:0] p [4][4];
  logic signed [WW-1:0] r [4];
  logic [SumW-1:0]      sum_d;
  tag_t                 tag_d;
  logic signed [WW-1:0] half;

  assign half = WW'(1) << (FracBits - 1);

  always_comb begin
    logic [DW:0] s;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = {{(WW-PW){prod_q[i][j][PW-1]}}, prod_q[i][j]};
      end
    end
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
    end
    case (op_q)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          r[i] = $signed({{(WW-DW){a_q[i][DW-1]}}, a_q[i]})
               + $signed({{(WW-DW){b_q[i][DW-1]}}, b_q[i]});
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          r[i] = (p[i][0] + half) >>> FracBits;
        end
      end
      OP_MUL: begin
        r[0] = (p[0][0] - p[1][1] - p[2][2] - p[3][3] + half) >>> FracBits;
        r[1] = (p[0][1] + p[1][0] + p[2][3] - p[3][2] + half) >>> FracBits;
        r[2] = (p[0][2] + p[2][0] + p[3][1] - p[1][3] + half) >>> FracBits;
        r[3] = (p[0][3] + p[3][0] + p[1][2] - p[2][1] + half) >>> FracBits;
      end
      OP_CONJ: begin
        r[0] = $signed({{(WW-DW){a_q[0][DW-1]}}, a_q[0]});
        for (int i = 1; i < 4; i++) begin
          r[i] = -$signed({{(WW-DW){a_q[i][DW-1]}}, a_q[i]});
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          r[i] = '0;
        end
      end
    endcase
    tag_d.vld = vld_q;
    tag_d.op  = op_q;
    tag_d.a   = a_q;
    tag_d.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s            = sat32(r[i]);
      tag_d.res[i] = s[DW-1:0];
      tag_d.sat    = tag_d.sat | s[DW];
    end
    // squares are never negative
    sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      sum_d = sum_d + {1'b0, prod_q[i][i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o <= sum_d;
    end
  end

endmodule

// File: hdl/qau_sqrt.sv
// pipelined digit-by-digit square root, one result bit per stage,
// with a final round-to-nearest stage; depends on qau_pkg
module qau_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [qau_pkg::SumW-1:0]   sum_i,
  input  qau_pkg::tag_t              tag_i,
  output logic [qau_pkg::LenW-1:0]   len_o,
  output qau_pkg::tag_t              tag_o
);
  import qau_pkg::*;

  logic [SqW-1:0]   x_q    [SqSteps];
  logic [RemW-1:0]  rem_q  [SqSteps];
  logic [RootW-1:0] root_q [SqSteps];
  tag_t             tag_q  [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_step
    logic [SqW-1:0]   x_p, x_d;
    logic [RemW-1:0]  rem_p, rem_d, cur, trial;
    logic [RootW-1:0] root_p, root_d;
    tag_t             tag_p;

    if (k == 0) begin : g_first
      assign x_p    = {{(SqW-SumW){1'b0}}, sum_i};
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = tag_i;
    end else begin : g_next
      assign x_p    = x_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign tag_p  = tag_q[k-1];
    end

    // bring down two bits, try subtracting 4*root+1
    always_comb begin
      cur   = {rem_p[RemW-3:0], x_p[SqW-1 -: 2]};
      trial = {{(RemW-RootW-2){1'b0}}, root_p, 2'b01};
      x_d   = x_p << 2;
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_p[RootW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_p[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  // round to nearest: bump when remainder exceeds root
  logic [LenW-1:0] len_d;
  assign len_d = root_q[SqSteps-1]
               + LenW'(rem_q[SqSteps-1] > {{(RemW-RootW){1'b0}}, root_q[SqSteps-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_q[SqSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_o <= len_d;
    end
  end

endmodule

// File: hdl/qau_div.sv
// four-lane pipelined restoring divider for normalize, one quotient bit
// per stage; depends on qau_pkg
module qau_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [qau_pkg::LenW-1:0]      len_i,
  input  qau_pkg::tag_t                 tag_i,
  output logic [qau_pkg::LenW-1:0]      len_o,
  output logic [3:0][qau_pkg::QW-1:0]   quo_o,
  output qau_pkg::tag_t                 tag_o
);
  import qau_pkg::*;

  // index 0 is the setup stage, index k+1 follows quotient step k
  logic [3:0][LenW-1:0] rem_q [QW+1];
  logic [3:0][QW-1:0]   nlo_q [QW+1];
  logic [3:0][QW-1:0]   quo_q [QW+1];
  logic [LenW-1:0]      len_q [QW+1];
  tag_t                 tag_q [QW+1];

  // setup: numerator |a| * 2^F + len/2, upper bits start the remainder
  logic [3:0][LenW-1:0] rem0_d;
  logic [3:0][QW-1:0]   nlo0_d;

  always_comb begin
    logic [DW-1:0]   mag;
    logic [NumW-1:0] num;
    for (int i = 0; i < 4; i++) begin
      mag       = tag_i.a[i][DW-1] ? (~tag_i.a[i] + DW'(1)) : tag_i.a[i];
      num       = {1'b0, mag, {FracBits{1'b0}}} + NumW'(len_i >> 1);
      rem0_d[i] = LenW'(num[NumW-1:QW]);
      nlo0_d[i] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_d;
      nlo_q[0] <= nlo0_d;
      quo_q[0] <= '0;
      len_q[0] <= len_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [3:0][LenW-1:0] rem_d;
    logic [3:0][QW-1:0]   nlo_d;
    logic [3:0][QW-1:0]   quo_d;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      logic [LenW:0] cur;
      for (int i = 0; i < 4; i++) begin
        cur      = {rem_q[k][i], nlo_q[k][i][QW-1]};
        nlo_d[i] = nlo_q[k][i] << 1;
        if (cur >= {1'b0, len_q[k]}) begin
          rem_d[i] = LenW'(cur - {1'b0, len_q[k]});
          quo_d[i] = {quo_q[k][i][QW-2:0], 1'b1};
        end else begin
          rem_d[i] = cur[LenW-1:0];
          quo_d[i] = {quo_q[k][i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        nlo_q[k+1] <= nlo_d;
        quo_q[k+1] <= quo_d;
        len_q[k+1] <= len_q[k];
      end
    end
  end

  assign len_o = len_q[QW];
  assign quo_o = quo_q[QW];
  assign tag_o = tag_q[QW];

endmodule

// File: hdl/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit, signed Q16.16: add, scale, Hamilton product,
// conjugate, magnitude and normalize. One word is taken every cycle unless the
// output stalls; each word passes the input register, product bank,
// combine, 33 square-root stages, rounding, divider setup, 17 quotient
// stages and output register; every op travels the full pipe. A stall on the
// output freezes the whole pipe, so ready follows the output register.
// depends on qau_pkg, qau_mul, qau_sqrt, qau_div and the defines header
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor, zero pad
  input  logic [295:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_w, res_x, res_y, res_z, magnitude, status[1:0], zero pad
  output logic [167:0] m_axis_tdata
);
  import qau_pkg::*;

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input register
  logic               in_vld_q;
  logic [2:0]         op_q;
  logic [3:0][DW-1:0] a_q, b_q;
  logic [DW-1:0]      s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= s_axis_tdata[2:0];
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= s_axis_tdata[3 + DW*i +: DW];
        b_q[i] <= s_axis_tdata[3 + DW*(4+i) +: DW];
      end
      s_q <= s_axis_tdata[3 + DW*8 +: DW];
    end
  end

  // datapath
  logic [SumW-1:0]      sum;
  tag_t                 mul_tag, sq_tag, div_tag;
  logic [LenW-1:0]      sq_len, div_len;
  logic [3:0][QW-1:0]   quo;

  qau_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_vld_q),
    .op_i   (op_q),
    .a_i    (a_q),
    .b_i    (b_q),
    .s_i    (s_q),
    .sum_o  (sum),
    .tag_o  (mul_tag)
  );

  qau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sum_i  (sum),
    .tag_i  (mul_tag),
    .len_o  (sq_len),
    .tag_o  (sq_tag)
  );

  qau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .len_i  (sq_len),
    .tag_i  (sq_tag),
    .len_o  (div_len),
    .quo_o  (quo),
    .tag_o  (div_tag)
  );

  // final result select
  logic [3:0][DW-1:0] res_d, res_q;
  logic [DW-1:0]      mag_d, mag_q;
  logic [1:0]         stat_d, stat_q;

  always_comb begin
    logic [DW-1:0] qx;
    qx     = '0;
    res_d  = div_tag.res;
    mag_d  = '0;
    stat_d = div_tag.sat ? STAT_SAT : STAT_OK;
    case (div_tag.op)
      OP_MAG: begin
        res_d = '0;
        if (div_len[LenW-1]) begin
          mag_d  = '1;
          stat_d = STAT_SAT;
        end else begin
          mag_d  = div_len[DW-1:0];
          stat_d = STAT_OK;
        end
      end
      OP_NORM: begin
        if (div_len == '0) begin
          res_d  = '0;
          stat_d = STAT_ZERO;
        end else begin
          for (int i = 0; i < 4; i++) begin
            qx       = {{(DW-QW){1'b0}}, quo[i]};
            res_d[i] = div_tag.a[i][DW-1] ? (~qx + DW'(1)) : qx;
          end
          stat_d = STAT_OK;
        end
      end
      default: begin
        res_d = div_tag.res;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_tag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      mag_q  <= mag_d;
      stat_q <= stat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, stat_q, mag_q, res_q[3], res_q[2], res_q[1], res_q[0]};

  // checks
  `QAU_ASSERT_NOW(a_status_code, out_vld_q, stat_q != 2'd3)
  `QAU_ASSERT_NOW(a_zero_len_clean, out_vld_q && stat_q == STAT_ZERO, res_q == '0 && mag_q == '0)
  `QAU_ASSERT_NOW(a_mag_only_ok, out_vld_q && mag_q != '0, stat_q == STAT_OK || stat_q == STAT_SAT)
  `QAU_ASSERT_NEXT(a_hold_stall, out_vld_q && !m_axis_tready, out_vld_q && $stable(res_q))

endmodule
